### hdl/fps_pkg.sv
// Shared types and constants of the fader percent smoother.
package fps_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int PCT_W       = 7;
    localparam int DIV_DVD_W   = 17;
    localparam int DIV_DVS_W   = 7;
    localparam int DIV_CNT_W   = 5;
    localparam int SCALED_W    = 24;

    localparam logic [PCT_W-1:0]     TOP_RESET = 7'd100;
    localparam logic [PCT_W-1:0]     PCT_MAX   = 7'd100;
    localparam logic [SCALED_W-1:0]  ROUND_ADD = 24'd512;
    localparam logic [DIV_DVD_W-1:0] GAIN_MUL  = 17'd100;
    localparam logic [SCALED_W-1:0]  PCT_MUL   = 24'd100;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

### hdl/fader_percent_smoother_top.sv
// Top level of the fader percent smoother: gain fix, percent scale, ring average.
// Flow: an accepted sample starts the 17-step gain divide, then passes the request, percent,
// sum and output stages; when top_percent is 0 the divide and percent stages are skipped.
// A new sample is taken only after the previous result is registered; a stalled result holds input.
// Reset: synchronous active low; ring reads as zero via valid bits, sum and slot
// clear, top_percent returns to 100.
module fader_percent_smoother_top
    import fps_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [9:0] adc_sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] smoothed_percent
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data   // [6:0] top_percent
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = $clog2(100 * WINDOW_LEN + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
    localparam int REC_SHIFT = SUM_W + 7;
    localparam logic [REC_SHIFT:0] REC_MUL = (REC_SHIFT+1)'(
        ((64'd1 << REC_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_PCT,
        S_SUM,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [PCT_W-1:0]     r_top;
    logic [SLOT_W-1:0]    r_slot;
    logic [SUM_W-1:0]     r_sum;
    logic [WINDOW_LEN-1:0] r_valid;
    logic [DIV_DVD_W-1:0] r_corr;
    logic [PCT_W-1:0]     r_pct;
    logic [PCT_W-1:0]     r_out;
    logic                 r_out_valid;
    logic [PCT_W-1:0]     r_rd;
    logic [PCT_W-1:0]     r_mem [WINDOW_LEN];
    t_div_req             r_div_req;
    t_div_rsp             div_rsp;

    logic                 s_accept;
    logic                 mem_we;
    logic [PCT_W-1:0]     old_pct;
    logic [SUM_W-1:0]     n_sum;
    logic [SCALED_W-1:0]  scaled;
    logic [SCALED_W-11:0] pct_raw;
    logic [PCT_W-1:0]     n_pct;
    logic [SUM_W+REC_SHIFT:0] avg_prod;

    fps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_out};

    assign scaled  = SCALED_W'(r_corr) * PCT_MUL + ROUND_ADD;
    assign pct_raw = scaled[SCALED_W-1:10];
    assign n_pct   = (pct_raw > (SCALED_W-10)'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];

    assign old_pct = r_valid[r_slot] ? r_rd : '0;
    assign n_sum   = r_sum - SUM_W'(old_pct) + SUM_W'(r_pct);
    assign mem_we  = (r_state == S_SUM);

    assign avg_prod = (SUM_W+REC_SHIFT+1)'(r_sum) * REC_MUL;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= r_pct;
        end
        r_rd <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= TOP_RESET;
            r_slot      <= '0;
            r_sum       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_div_req   <= '0;
        end else begin
            r_div_req.start <= (r_state == S_IDLE) && s_accept && (r_top != '0);
            if (i_cfg_valid) begin
                r_top <= i_cfg_data[PCT_W-1:0];
            end
            r_out_valid <= (r_state == S_OUT) || (r_out_valid && !i_m_tready);
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        if (r_top == '0) begin
                            r_pct   <= PCT_MAX;
                            r_state <= S_SUM;
                        end else begin
                            r_div_req.dividend <=
                                DIV_DVD_W'(i_s_tdata[SAMPLE_W-1:0]) * GAIN_MUL;
                            r_div_req.divisor  <= r_top;
                            r_state            <= S_DIV1;
                        end
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_corr  <= div_rsp.quotient;
                        r_state <= S_PCT;
                    end
                end
                S_PCT: begin
                    r_pct   <= n_pct;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum           <= n_sum;
                    r_valid[r_slot] <= 1'b1;
                    r_slot          <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out   <= avg_prod[REC_SHIFT +: PCT_W];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/fps_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module fps_div
    import fps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [DIV_DVS_W-1:0] r_rem;
    logic [DIV_DVS_W-1:0] r_dvs;
    logic [DIV_DVD_W-1:0] r_quo;

    logic [DIV_DVS_W:0]   trial;
    logic                 fits;
    logic [DIV_DVS_W:0]   diff;

    assign trial = {r_rem, r_quo[DIV_DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
                r_rem   <= '0;
                r_dvs   <= i_req.divisor;
                r_quo   <= i_req.dividend;
            end else if (r_busy) begin
                r_rem   <= fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
                r_quo   <= {r_quo[DIV_DVD_W-2:0], fits};
                r_count <= r_count + 1'b1;
                if (r_count == DIV_CNT_W'(DIV_DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
